// ----- hw/rtl/htfa_pkg.sv -----
package htfa_pkg;

  localparam int ACTION_W = 2;
  localparam int HANDLE_W = 6;
  localparam int DB_W = 32;
  localparam int PREFIX_W = 64;
  localparam int PLEN_W = 4;
  localparam int MODE_W = 2;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [ACTION_W-1:0] ACT_OPEN = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLOSE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_MODE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd3;

  typedef struct packed {
    logic set_live;
    logic clr_live;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/htfa_cell.sv -----
module htfa_cell #(
  parameter int IdxW = 6,
  parameter int CntW = 7
) (
  input  logic                clk,
  input  htfa_pkg::cell_ctrl_t ctrl,
  input  logic [IdxW-1:0]     cell_index,
  input  logic [CntW-1:0]     slot_count,
  input  logic                found_in,
  input  logic [IdxW-1:0]     index_in,
  output logic                found_out,
  output logic [IdxW-1:0]     index_out,
  output logic                live
);
  import htfa_pkg::*;

  logic free_here;

  always_comb begin
    free_here = (CntW'(cell_index) < slot_count) && !live;
  end

  always_ff @(posedge clk) begin
    if (ctrl.set_live) begin
      live <= 1'b1;
    end else if (ctrl.clr_live) begin
      live <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    found_out <= free_here || found_in;
    index_out <= free_here ? cell_index : index_in;
  end

endmodule

// ----- hw/rtl/htfa_mem.sv -----
module htfa_mem #(
  parameter int Depth = 64,
  parameter int AddrW = 6,
  parameter int DataW = 102
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [DataW-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [DataW-1:0] rdata
);
  import htfa_pkg::*;

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/handle_table_first_free_allocator.sv -----
// Handle table that reuses the lowest closed slot before appending a new one. A request is
// accepted only in the idle state; it then passes through an execute state, a read state for
// a lookup (which reads the slot memory), and a finish state, in which the result is
// registered once the output is free. The next request can be accepted after the block has
// returned to idle. A result that is still waiting holds the block in its finish state, which
// stalls the following request. Each open slot holds an occupancy flag in one cell of a row of
// MAX_SLOTS cells; the row passes the lowest free index one cell per clock towards cell 0,
// so after an open or close has changed the row, a following open waits in the execute state
// until that change has passed through the whole row. The same wait applies after reset.
// Slot contents live in a single-port-write, single-port-read memory. The handle limit
// register may be written only while no transaction is in progress.
module handle_table_first_free_allocator #(
  parameter int MAX_SLOTS = 64,
  parameter int PREFIX_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [htfa_pkg::LIMIT_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [htfa_pkg::ACTION_W-1:0]     action,
  input  logic [htfa_pkg::HANDLE_W-1:0]     handle,
  input  logic [htfa_pkg::DB_W-1:0]         db_id,
  input  logic [htfa_pkg::PREFIX_W-1:0]     prefix_value,
  input  logic [htfa_pkg::PLEN_W-1:0]       prefix_length,
  input  logic [htfa_pkg::MODE_W-1:0]       access_mode,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [htfa_pkg::STATUS_W-1:0]     status,
  output logic [htfa_pkg::HANDLE_W-1:0]     granted_handle,
  output logic [htfa_pkg::DB_W-1:0]         entry_db,
  output logic [htfa_pkg::PREFIX_W-1:0]     entry_prefix,
  output logic [htfa_pkg::PLEN_W-1:0]       entry_prefix_length,
  output logic [htfa_pkg::MODE_W-1:0]       entry_mode
);
  import htfa_pkg::*;

  localparam int IdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CntW = $clog2(MAX_SLOTS + 1);
  localparam int CmpW = (CntW > LIMIT_W) ? CntW : LIMIT_W;
  localparam int PfxW = PREFIX_BYTES * 8;
  localparam int DataW = DB_W + PfxW + PLEN_W + MODE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_FIN = 2'd3;

  logic [1:0]           state;
  logic [LIMIT_W-1:0]   handle_limit;
  logic [CntW-1:0]      slot_count;
  logic [CntW-1:0]      settle;

  logic [ACTION_W-1:0]  req_action;
  logic [HANDLE_W-1:0]  req_handle;
  logic [DB_W-1:0]      req_db;
  logic [PREFIX_W-1:0]  req_prefix;
  logic [PLEN_W-1:0]    req_len;
  logic [MODE_W-1:0]    req_mode;

  logic [STATUS_W-1:0]  res_status;
  logic [HANDLE_W-1:0]  res_granted;
  logic                 res_lookup;

  logic [MAX_SLOTS:0]   chain_found;
  logic [IdxW-1:0]      chain_index [MAX_SLOTS+1];
  logic [MAX_SLOTS-1:0] live;
  cell_ctrl_t           cell_ctrl [MAX_SLOTS];

  logic [CmpW-1:0]      count_ext;
  logic [CmpW-1:0]      handle_ext;
  logic [CmpW-1:0]      limit_ext;
  logic [CmpW-1:0]      lim_eff;
  logic [IdxW-1:0]      h_idx;
  logic                 h_ok;
  logic                 open_req;
  logic                 open_go;
  logic                 can_append;
  logic                 do_alloc;
  logic                 do_close;
  logic                 do_read;
  logic [IdxW-1:0]      alloc_idx;
  logic [PLEN_W-1:0]    len_sat;
  logic [DataW-1:0]     wdata;
  logic [DataW-1:0]     rdata;
  logic                 out_free;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    count_ext = CmpW'(slot_count);
    handle_ext = CmpW'(req_handle);
    limit_ext = CmpW'(handle_limit);
    lim_eff = (limit_ext < CmpW'(MAX_SLOTS)) ? limit_ext : CmpW'(MAX_SLOTS);
    h_idx = handle_ext[IdxW-1:0];
    h_ok = (handle_ext < count_ext) && live[h_idx];
    open_req = (state == S_EXEC) && (req_action == ACT_OPEN) && (req_mode != MODE_NONE);
    open_go = open_req && (settle == '0);
    can_append = count_ext < lim_eff;
    alloc_idx = chain_found[0] ? chain_index[0] : slot_count[IdxW-1:0];
    do_alloc = open_go && (chain_found[0] || can_append);
    do_close = (state == S_EXEC) && (req_action == ACT_CLOSE) && h_ok;
    do_read = (state == S_EXEC) && (req_action == ACT_LOOKUP) && h_ok;
    len_sat = (req_len > PLEN_W'(PREFIX_BYTES)) ? PLEN_W'(PREFIX_BYTES) : req_len;
    wdata = {req_db, req_prefix[PfxW-1:0], len_sat, req_mode};
  end

  assign chain_found[MAX_SLOTS] = 1'b0;
  assign chain_index[MAX_SLOTS] = '0;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    always_comb begin
      cell_ctrl[i].set_live = do_alloc && (alloc_idx == IdxW'(i));
      cell_ctrl[i].clr_live = do_close && (h_idx == IdxW'(i));
    end

    htfa_cell #(
      .IdxW(IdxW),
      .CntW(CntW)
    ) u_cell (
      .clk(clk),
      .ctrl(cell_ctrl[i]),
      .cell_index(IdxW'(i)),
      .slot_count(slot_count),
      .found_in(chain_found[i+1]),
      .index_in(chain_index[i+1]),
      .found_out(chain_found[i]),
      .index_out(chain_index[i]),
      .live(live[i])
    );
  end

  htfa_mem #(
    .Depth(MAX_SLOTS),
    .AddrW(IdxW),
    .DataW(DataW)
  ) u_mem (
    .clk(clk),
    .we(do_alloc),
    .waddr(alloc_idx),
    .wdata(wdata),
    .re(do_read),
    .raddr(h_idx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_action <= action;
      req_handle <= handle;
      req_db <= db_id;
      req_prefix <= prefix_value;
      req_len <= prefix_length;
      req_mode <= access_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      handle_limit <= LIMIT_RESET;
      slot_count <= '0;
      settle <= CntW'(MAX_SLOTS);
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        handle_limit <= cfg_data;
      end
      if (do_alloc || do_close) begin
        settle <= CntW'(MAX_SLOTS);
      end else if (settle != '0) begin
        settle <= settle - 1'b1;
      end
      if (do_alloc && !chain_found[0]) begin
        slot_count <= slot_count + 1'b1;
      end
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!(open_req && (settle != '0))) begin
            state <= do_read ? S_READ : S_FIN;
          end
        end
        S_READ: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      res_granted <= '0;
      res_lookup <= 1'b0;
      priority case (1'b1)
        (req_action == ACT_OPEN) && (req_mode == MODE_NONE): begin
          res_status <= ST_BAD_MODE;
        end
        (req_action == ACT_OPEN): begin
          if (do_alloc) begin
            res_status <= ST_OK;
            res_granted <= HANDLE_W'(alloc_idx);
          end else begin
            res_status <= ST_TOO_MANY;
          end
        end
        do_close: begin
          res_status <= ST_OK;
        end
        do_read: begin
          res_status <= ST_OK;
          res_lookup <= 1'b1;
        end
        default: begin
          res_status <= ST_BAD_HANDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      status <= res_status;
      granted_handle <= res_granted;
      if (res_lookup) begin
        entry_db <= rdata[DataW-1 -: DB_W];
        entry_prefix <= PREFIX_W'(rdata[PLEN_W+MODE_W +: PfxW]);
        entry_prefix_length <= rdata[MODE_W +: PLEN_W];
        entry_mode <= rdata[MODE_W-1:0];
      end else begin
        entry_db <= '0;
        entry_prefix <= '0;
        entry_prefix_length <= '0;
        entry_mode <= '0;
      end
    end
  end

endmodule

// ----- tb/tb_handle_table_first_free_allocator.sv -----
`timescale 1ns / 1ps

module tb_handle_table_first_free_allocator;
  import htfa_pkg::*;

  localparam int SLOT_CAPACITY = 64;
  localparam int PREFIX_BYTE_COUNT = 8;
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [HANDLE_W-1:0] handle;
    logic [DB_W-1:0]     db;
    logic [PREFIX_W-1:0] prefix;
    logic [PLEN_W-1:0]   plen;
    logic [MODE_W-1:0]   mode;
  } handle_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] granted;
    logic [DB_W-1:0]     db;
    logic [PREFIX_W-1:0] prefix;
    logic [PLEN_W-1:0]   plen;
    logic [MODE_W-1:0]   mode;
  } handle_reply_t;

  class handle_table_shadow;
    logic [LIMIT_W-1:0]  limit = LIMIT_RESET;
    int unsigned         high_water = 0;
    logic [MODE_W-1:0]   slot_mode   [SLOT_CAPACITY];
    logic [DB_W-1:0]     slot_db     [SLOT_CAPACITY];
    logic [PREFIX_W-1:0] slot_prefix [SLOT_CAPACITY];
    logic [PLEN_W-1:0]   slot_plen   [SLOT_CAPACITY];
    handle_reply_t       expected_replies[$];
    int unsigned         mismatches = 0;

    function bit is_live(logic [HANDLE_W-1:0] h);
      return h < high_water && h < SLOT_CAPACITY && slot_mode[h] != MODE_NONE;
    endfunction

    function void fill_slot(int unsigned i, handle_req_t r);
      logic [PREFIX_W-1:0] keep;
      keep = {PREFIX_W{1'b1}} >> (PREFIX_W - 8 * PREFIX_BYTE_COUNT);
      slot_db[i] = r.db;
      slot_prefix[i] = r.prefix & keep;
      slot_plen[i] = (r.plen > PREFIX_BYTE_COUNT) ? PLEN_W'(PREFIX_BYTE_COUNT) : r.plen;
      slot_mode[i] = r.mode;
    endfunction

    function int pick_live();
      int live[$];
      for (int i = 0; i < high_water; i++)
        if (slot_mode[i] != MODE_NONE) live = {live, i};
      if (live.size() == 0) return -1;
      return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function void apply_request(handle_req_t r);
      handle_reply_t e;
      int            free_slot;
      int unsigned   cap;
      e = '0;
      e.status = ST_BAD_HANDLE;
      free_slot = -1;
      cap = (limit > SLOT_CAPACITY) ? SLOT_CAPACITY : limit;
      case (r.action)
        ACT_OPEN: begin
          if (r.mode == MODE_NONE) begin
            e.status = ST_BAD_MODE;
          end else begin
            for (int i = 0; i < high_water; i++)
              if (free_slot < 0 && slot_mode[i] == MODE_NONE) free_slot = i;
            if (free_slot >= 0) begin
              fill_slot(free_slot, r);
              e.granted = HANDLE_W'(free_slot);
              e.status = ST_OK;
            end else if (high_water < cap) begin
              fill_slot(high_water, r);
              e.granted = HANDLE_W'(high_water);
              high_water++;
              e.status = ST_OK;
            end else begin
              e.status = ST_TOO_MANY;
            end
          end
        end
        ACT_CLOSE: begin
          if (is_live(r.handle)) begin
            slot_mode[r.handle] = MODE_NONE;
            e.status = ST_OK;
          end
        end
        ACT_LOOKUP: begin
          if (is_live(r.handle)) begin
            e.db = slot_db[r.handle];
            e.prefix = slot_prefix[r.handle];
            e.plen = slot_plen[r.handle];
            e.mode = slot_mode[r.handle];
            e.status = ST_OK;
          end
        end
        default: ;
      endcase
      expected_replies = {expected_replies, e};
    endfunction

    function void compare_reply(handle_reply_t got);
      handle_reply_t e;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected reply: status %0d handle %0d", got.status, got.granted);
        return;
      end
      e = expected_replies.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Reply mismatch: status %0d/%0d handle %0d/%0d db %h/%h",
                   e.status, got.status, e.granted, got.granted, e.db, got.db);
          $display("  prefix %h/%h length %0d/%0d mode %0d/%0d (expected/actual)",
                   e.prefix, got.prefix, e.plen, got.plen, e.mode, got.mode);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LIMIT_W-1:0]  cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] action = ACT_OPEN;
  logic [HANDLE_W-1:0] handle = '0;
  logic [DB_W-1:0]     db_id = '0;
  logic [PREFIX_W-1:0] prefix_value = '0;
  logic [PLEN_W-1:0]   prefix_length = '0;
  logic [MODE_W-1:0]   access_mode = MODE_NONE;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] granted_handle;
  logic [DB_W-1:0]     entry_db;
  logic [PREFIX_W-1:0] entry_prefix;
  logic [PLEN_W-1:0]   entry_prefix_length;
  logic [MODE_W-1:0]   entry_mode;

  handle_table_shadow shadow = new();
  int                 stall_style = 0;
  int                 stall_cycles = 0;

  handle_table_first_free_allocator #(
    .MAX_SLOTS(SLOT_CAPACITY),
    .PREFIX_BYTES(PREFIX_BYTE_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .handle(handle),
    .db_id(db_id),
    .prefix_value(prefix_value),
    .prefix_length(prefix_length),
    .access_mode(access_mode),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .granted_handle(granted_handle),
    .entry_db(entry_db),
    .entry_prefix(entry_prefix),
    .entry_prefix_length(entry_prefix_length),
    .entry_mode(entry_mode)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      shadow.compare_reply({status, granted_handle, entry_db, entry_prefix,
                            entry_prefix_length, entry_mode});
    if (stall_cycles == 0) begin
      stall_style = $urandom_range(0, 2);
      stall_cycles = $urandom_range(8, 80);
    end
    stall_cycles--;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  function automatic handle_req_t mk(logic [ACTION_W-1:0] a, logic [HANDLE_W-1:0] h,
                                     logic [DB_W-1:0] d, logic [PREFIX_W-1:0] p,
                                     logic [PLEN_W-1:0] l, logic [MODE_W-1:0] m);
    handle_req_t r;
    r = {a, h, d, p, l, m};
    return r;
  endfunction

  function automatic handle_req_t random_request(int open_pct);
    handle_req_t r;
    int          roll;
    int          live;
    roll = $urandom_range(0, 99);
    if (roll < open_pct) r.action = ACT_OPEN;
    else if (roll < open_pct + (100 - open_pct) * 2 / 5) r.action = ACT_CLOSE;
    else if (roll < 96) r.action = ACT_LOOKUP;
    else r.action = ACT_SPARE;
    live = shadow.pick_live();
    if (live >= 0 && $urandom_range(0, 3) != 0) r.handle = HANDLE_W'(live);
    else r.handle = HANDLE_W'($urandom_range(0, 63));
    case ($urandom_range(0, 7))
      0: r.db = '0;
      1: r.db = '1;
      default: r.db = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0: r.prefix = '0;
      1: r.prefix = '1;
      default: r.prefix = {$urandom, $urandom};
    endcase
    roll = $urandom_range(0, 10);
    r.plen = (roll <= 8) ? PLEN_W'(roll) : PLEN_W'($urandom_range(9, 15));
    r.mode = ($urandom_range(0, 7) == 0) ? MODE_NONE : MODE_W'($urandom_range(1, 3));
    return r;
  endfunction

  task automatic send_request(input handle_req_t r);
    in_valid <= 1'b1;
    action <= r.action;
    handle <= r.handle;
    db_id <= r.db;
    prefix_value <= r.prefix;
    prefix_length <= r.plen;
    access_mode <= r.mode;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.apply_request(r);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    while (shadow.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow.limit = value;
  endtask

  task automatic run_random(input int count, input int open_pct);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      send_request(random_request(open_pct));
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_limit(7'd3);

    send_request(mk(ACT_LOOKUP, 6'd0, '0, '0, 4'd0, MODE_NONE));
    send_request(mk(ACT_CLOSE, 6'd63, '1, '1, 4'd15, 2'd3));
    send_request(mk(ACT_SPARE, 6'd0, 32'h1, 64'h1, 4'd1, 2'd1));
    send_request(mk(ACT_OPEN, 6'd0, 32'hdead_beef, 64'h1, 4'd2, MODE_NONE));
    send_request(mk(ACT_OPEN, 6'd0, '0, '0, 4'd0, 2'd1));
    send_request(mk(ACT_OPEN, 6'd63, '1, '1, 4'd15, 2'd2));
    send_request(mk(ACT_OPEN, 6'd5, 32'h1234_5678, 64'h0123_4567_89ab_cdef, 4'd8, 2'd3));
    send_request(mk(ACT_OPEN, 6'd0, 32'h5, 64'h5, 4'd3, 2'd1));
    send_request(mk(ACT_LOOKUP, 6'd0, '1, '1, 4'd15, 2'd3));
    send_request(mk(ACT_LOOKUP, 6'd1, '0, '0, 4'd0, MODE_NONE));
    send_request(mk(ACT_LOOKUP, 6'd2, '0, '0, 4'd0, MODE_NONE));
    send_request(mk(ACT_CLOSE, 6'd1, '0, '0, 4'd0, MODE_NONE));
    send_request(mk(ACT_CLOSE, 6'd1, '0, '0, 4'd0, MODE_NONE));
    send_request(mk(ACT_LOOKUP, 6'd1, '0, '0, 4'd0, MODE_NONE));
    send_request(mk(ACT_OPEN, 6'd0, 32'hcafe_f00d, 64'hffee_ddcc_bbaa_9988, 4'd9, 2'd2));
    send_request(mk(ACT_LOOKUP, 6'd1, '0, '0, 4'd0, MODE_NONE));
    send_request(mk(ACT_LOOKUP, 6'd3, '0, '0, 4'd0, MODE_NONE));
    send_request(mk(ACT_LOOKUP, 6'd63, '0, '0, 4'd0, MODE_NONE));
    send_request(mk(ACT_CLOSE, 6'd0, '0, '0, 4'd0, MODE_NONE));
    send_request(mk(ACT_OPEN, 6'd0, 32'h7, 64'h7, 4'd1, 2'd3));
    send_request(mk(ACT_CLOSE, 6'd2, '0, '0, 4'd0, MODE_NONE));
    in_valid <= 1'b0;

    write_limit(7'd0);
    run_random(60, 40);
    write_limit(7'd127);
    run_random(150, 60);
    write_limit(7'd64);
    run_random(80, 45);
    write_limit(7'd20);
    run_random(80, 45);

    while (shadow.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/htfa_pkg.sv
hw/rtl/htfa_cell.sv
hw/rtl/htfa_mem.sv
hw/rtl/handle_table_first_free_allocator.sv
tb/tb_handle_table_first_free_allocator.sv
